### design/bdcc_pkg.sv
// Shared types, sizes and codes for the binary digit crop-and-centre core.
// Used by every module in this folder; depends on nothing else.
package bdcc_pkg;

    localparam int MAX_ROWS = 128;
    localparam int MAX_COLS = 128;
    localparam int OUT_ROWS = 70;
    localparam int OUT_COLS = 50;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * MAX_COLS;

    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 7;
    localparam int DIM_W    = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'd1;

    localparam logic [COORD_W-1:0] MIN_RESET = 7'd127;
    localparam logic [COORD_W-1:0] MAX_RESET = 7'd0;

    typedef struct packed {
        logic               any_ink;
        logic [COORD_W-1:0] min_row;
        logic [COORD_W-1:0] max_row;
        logic [COORD_W-1:0] min_col;
        logic [COORD_W-1:0] max_col;
    } box_t;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] left;
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
        logic               empty;
        logic               oversize;
    } res_t;

endpackage

### design/bdcc_box_track.sv
// Configuration registers and bounding-box tracker of the crop-and-centre core.
// Depends on bdcc_pkg.
module bdcc_box_track
    import bdcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 step_en,
    input  logic [FUNC_W-1:0]    func,
    input  logic [COORD_W-1:0]   row,
    input  logic [COORD_W-1:0]   col,
    input  logic                 pixel,
    output box_t                 box,
    output logic                 wr_ok
);

    localparam logic [CFG_W-1:0] ROW_LIM = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COL_LIM = CFG_W'(MAX_COLS);

    logic [CFG_W-1:0] image_rows_reg;
    logic [CFG_W-1:0] image_cols_reg;
    logic [CFG_W-1:0] rows_lim;
    logic [CFG_W-1:0] cols_lim;
    box_t             box_reg;
    box_t             box_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_rows_reg <= ROW_LIM;
            image_cols_reg <= COL_LIM;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_wdata;
                CFG_IMAGE_COLS: image_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign rows_lim = (image_rows_reg > ROW_LIM) ? ROW_LIM : image_rows_reg;
    assign cols_lim = (image_cols_reg > COL_LIM) ? COL_LIM : image_cols_reg;

    assign wr_ok = (func == FUNC_WRITE) && ({1'b0, row} < rows_lim)
                   && ({1'b0, col} < cols_lim);

    always_comb begin
        box_next = box_reg;
        if (func == FUNC_CLEAR) begin
            box_next.any_ink = 1'b0;
            box_next.min_row = MIN_RESET;
            box_next.max_row = MAX_RESET;
            box_next.min_col = MIN_RESET;
            box_next.max_col = MAX_RESET;
        end else if (wr_ok && pixel) begin
            box_next.any_ink = 1'b1;
            if (row < box_reg.min_row) box_next.min_row = row;
            if (row > box_reg.max_row) box_next.max_row = row;
            if (col < box_reg.min_col) box_next.min_col = col;
            if (col > box_reg.max_col) box_next.max_col = col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg.any_ink <= 1'b0;
            box_reg.min_row <= MIN_RESET;
            box_reg.max_row <= MAX_RESET;
            box_reg.min_col <= MIN_RESET;
            box_reg.max_col <= MAX_RESET;
        end else if (step_en) begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

### design/bdcc_centre_map.sv
// Maps an output frame coordinate onto the centred bounding box and gives the
// frame store address and the box fields of a result. Depends on bdcc_pkg.
module bdcc_centre_map
    import bdcc_pkg::*;
(
    input  box_t               box,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    output res_t               res,
    output logic [ADDR_W-1:0]  rd_addr
);

    localparam logic [DIM_W-1:0] OUT_R = DIM_W'(OUT_ROWS);
    localparam logic [DIM_W-1:0] OUT_C = DIM_W'(OUT_COLS);
    localparam logic [DIM_W-1:0] SRC_R = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] SRC_C = DIM_W'(MAX_COLS);

    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] shown_r;
    logic [DIM_W-1:0] shown_c;
    logic [DIM_W-1:0] before_r;
    logic [DIM_W-1:0] before_c;
    logic [DIM_W-1:0] pos_r;
    logic [DIM_W-1:0] pos_c;
    logic [DIM_W-1:0] src_r;
    logic [DIM_W-1:0] src_c;
    logic             in_r;
    logic             in_c;

    always_comb begin
        rows = '0;
        cols = '0;
        if (box.any_ink) begin
            rows = DIM_W'(box.max_row - box.min_row) + 8'd1;
            cols = DIM_W'(box.max_col - box.min_col) + 8'd1;
        end
        shown_r  = (rows > OUT_R) ? OUT_R : rows;
        shown_c  = (cols > OUT_C) ? OUT_C : cols;
        before_r = (OUT_R - shown_r) >> 1;
        before_c = (OUT_C - shown_c) >> 1;
        pos_r    = {1'b0, row};
        pos_c    = {1'b0, col};
        in_r     = (pos_r < OUT_R) && (pos_r >= before_r) && (pos_r < before_r + shown_r);
        in_c     = (pos_c < OUT_C) && (pos_c >= before_c) && (pos_c < before_c + shown_c);
        src_r    = {1'b0, box.min_row} + (pos_r - before_r);
        src_c    = {1'b0, box.min_col} + (pos_c - before_c);

        res.hit      = box.any_ink && in_r && in_c && (src_r < SRC_R) && (src_c < SRC_C);
        res.top      = box.any_ink ? box.min_row : '0;
        res.left     = box.any_ink ? box.min_col : '0;
        res.rows     = rows;
        res.cols     = cols;
        res.empty    = !box.any_ink;
        res.oversize = box.any_ink && ((rows > OUT_R) || (cols > OUT_C));
        rd_addr      = {src_r[ROW_W-1:0], src_c[COL_W-1:0]};
    end

endmodule

### design/bdcc_frame_store.sv
// Single-bit frame store of the crop-and-centre core, one write and one
// registered read port. Depends on bdcc_pkg.
module bdcc_frame_store
    import bdcc_pkg::*;
(
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    logic mem [0:DEPTH-1];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/binary_digit_crop_and_centre_core.sv
// Top level of the binary digit crop-and-centre core: input register, box
// tracker, centring map, frame store and result register. Depends on bdcc_pkg.
//
// Channel   Dir  Contents
// s_        in   func, row, col, pixel (tdata bits 16:0)
// m_        out  out_pixel, box_top, box_left, box_rows, box_cols, box_empty,
//                box_oversize (tdata bits 32:0)
// cfg_      in   write of image_rows (index 0) or image_cols (index 1)
//
// One item is taken every cycle while the output register is not stalled by m_tready.
// A read's item is held in the input register, then the result register and the
// registered frame store read are loaded at the same edge and present its result.
// A result waiting in the output register stalls both stages only when m_tready is
// low. The frame store is not cleared at reset and needs no sweep; reset empties the
// box, sets both configuration registers to 128 and clears the valid flags.
module binary_digit_crop_and_centre_core
    import bdcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // func, row, col, pixel, zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // out_pixel, box_top, box_left,
                                             // box_rows, box_cols, box_empty,
                                             // box_oversize, zero fill
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               pixel_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    res_t               res_reg;
    res_t               res;
    box_t               box;
    logic               wr_ok;
    logic               advance;
    logic               step_en;
    logic               is_read;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_data;

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance || !in_valid_reg;
    assign step_en  = in_valid_reg && advance;
    assign is_read  = func_reg == FUNC_READ;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign m_valid_next  = advance ? (in_valid_reg && is_read) : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg  <= s_tdata[1:0];
            row_reg   <= s_tdata[8:2];
            col_reg   <= s_tdata[15:9];
            pixel_reg <= s_tdata[16];
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && is_read) begin
            res_reg <= res;
        end
    end

    bdcc_box_track u_box_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_en   (step_en),
        .func      (func_reg),
        .row       (row_reg),
        .col       (col_reg),
        .pixel     (pixel_reg),
        .box       (box),
        .wr_ok     (wr_ok)
    );

    bdcc_centre_map u_centre_map (
        .box     (box),
        .row     (row_reg),
        .col     (col_reg),
        .res     (res),
        .rd_addr (rd_addr)
    );

    bdcc_frame_store u_frame_store (
        .aclk    (aclk),
        .wr_en   (step_en && wr_ok),
        .wr_addr ({row_reg[ROW_W-1:0], col_reg[COL_W-1:0]}),
        .wr_data (pixel_reg),
        .rd_en   (step_en && is_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, res_reg.oversize, res_reg.empty, res_reg.cols, res_reg.rows,
                       res_reg.left, res_reg.top, rd_data && res_reg.hit};

endmodule

### tb/sv/bdcc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the binary digit crop-and-centre core: it follows the input and
// result channels and the register port, predicts every read and compares it.
// Depends on bdcc_pkg.
module bdcc_checker
    import bdcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int unsigned          fail_count,
    output int unsigned          pending
);

    bit                 ink_store [DEPTH];
    bit                 has_ink;
    logic [COORD_W-1:0] top_row;
    logic [COORD_W-1:0] bottom_row;
    logic [COORD_W-1:0] left_col;
    logic [COORD_W-1:0] right_col;
    logic [CFG_W-1:0]   rows_in_use;
    logic [CFG_W-1:0]   cols_in_use;
    res_t               crop_q [$];

    task automatic clear_box();
        has_ink    = 1'b0;
        top_row    = MIN_RESET;
        bottom_row = MAX_RESET;
        left_col   = MIN_RESET;
        right_col  = MAX_RESET;
    endtask

    function automatic bit map_to_box(int unsigned pos, int unsigned len,
                                      int unsigned frame_len, output int unsigned offset);
        int unsigned shown;
        int unsigned lead;
        shown  = (len > frame_len) ? frame_len : len;
        lead   = (frame_len - shown) / 2;
        offset = pos - lead;
        return pos >= lead && pos < lead + shown;
    endfunction

    function automatic res_t crop_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        res_t        res;
        int unsigned height;
        int unsigned width;
        int unsigned dr;
        int unsigned dc;
        res       = '0;
        res.empty = !has_ink;
        if (has_ink) begin
            height       = int'(bottom_row) - int'(top_row) + 1;
            width        = int'(right_col) - int'(left_col) + 1;
            res.top      = top_row;
            res.left     = left_col;
            res.rows     = DIM_W'(height);
            res.cols     = DIM_W'(width);
            res.oversize = height > OUT_ROWS || width > OUT_COLS;
            if (row < OUT_ROWS && col < OUT_COLS &&
                map_to_box(row, height, OUT_ROWS, dr) &&
                map_to_box(col, width, OUT_COLS, dc)) begin
                res.hit = ink_store[(top_row + dr) * MAX_COLS + left_col + dc];
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        res_t               want;
        logic [FUNC_W-1:0]  func;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               pix;
        if (!aresetn) begin
            clear_box();
            rows_in_use = CFG_W'(MAX_ROWS);
            cols_in_use = CFG_W'(MAX_COLS);
            crop_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IMAGE_ROWS: rows_in_use = cfg_wdata;
                    CFG_IMAGE_COLS: cols_in_use = cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (crop_q.size() == 0) begin
                    $error("result transfer %h arrived with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    want = crop_q.pop_front();
                    check_field("out_pixel", want.hit, m_tdata[0]);
                    check_field("box_top", want.top, m_tdata[7:1]);
                    check_field("box_left", want.left, m_tdata[14:8]);
                    check_field("box_rows", want.rows, m_tdata[22:15]);
                    check_field("box_cols", want.cols, m_tdata[30:23]);
                    check_field("box_empty", want.empty, m_tdata[31]);
                    check_field("box_oversize", want.oversize, m_tdata[32]);
                end
            end
            if (s_tvalid && s_tready) begin
                func = s_tdata[1:0];
                row  = s_tdata[8:2];
                col  = s_tdata[15:9];
                pix  = s_tdata[16];
                case (func)
                    FUNC_CLEAR: clear_box();
                    FUNC_WRITE: begin
                        // Coordinates never exceed the store, so a register value
                        // above the store size simply lets every write through.
                        if (row < rows_in_use && col < cols_in_use) begin
                            ink_store[row * MAX_COLS + col] = pix;
                            if (pix) begin
                                if (row < top_row) top_row = row;
                                if (row > bottom_row) bottom_row = row;
                                if (col < left_col) left_col = col;
                                if (col > right_col) right_col = col;
                                has_ink = 1'b1;
                            end
                        end
                    end
                    FUNC_READ: crop_q.push_back(crop_pixel(row, col));
                    default: ;
                endcase
            end
        end
        pending = crop_q.size();
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the crop-and-centre testbench: clock, reset, register writes and stimulus
// for both channels, with bdcc_checker beside the core giving the verdict.
// Depends on bdcc_pkg, binary_digit_crop_and_centre_core and bdcc_checker.
module tb;
    import bdcc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Filled corner of the store: a square with a tall and a wide strip beside it.
    localparam int SQ     = 8;
    localparam int ARM    = 2;
    localparam int FILL_R = 72;
    localparam int FILL_C = 52;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // func, row, col, pixel, zero fill
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // out_pixel, box_top, box_left, box_rows,
                                     // box_cols, box_empty, box_oversize, zero fill
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int unsigned          fail_count;
    int unsigned          pending;

    int unsigned          random_items;
    bit                   counting;
    bit                   quiet;
    bit                   hold_req;
    bit                   hold_done;
    logic [CFG_W-1:0]     img_rows;
    logic [CFG_W-1:0]     img_cols;

    binary_digit_crop_and_centre_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bdcc_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_item(logic [FUNC_W-1:0] func, logic [COORD_W-1:0] row,
                             logic [COORD_W-1:0] col, logic pix);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pix, col, row, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        if (counting && (func == FUNC_READ || func == FUNC_CLEAR ||
            (func == FUNC_WRITE && row < img_rows && col < img_cols))) begin
            random_items++;
            if (random_items == 40) hold_req = 1'b1;
            if (random_items >= 200) quiet = 1'b1;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_image(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_IMAGE_ROWS;
        cfg_wdata <= rows;
        img_rows  = rows;
        @(negedge aclk);
        cfg_index <= CFG_IMAGE_COLS;
        cfg_wdata <= cols;
        img_cols  = cols;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Noise writes carry no ink so that no box ever leaves the filled corner.
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_item(FUNC_NONE, COORD_W'($urandom_range(0, 127)),
                         COORD_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            1: send_item(FUNC_WRITE, COORD_W'($urandom_range(0, 127)),
                         COORD_W'($urandom_range(0, 127)), 1'b0);
            default: send_item(FUNC_READ, COORD_W'($urandom_range(0, 127)),
                               COORD_W'($urandom_range(0, 127)),
                               1'($urandom_range(0, 1)));
        endcase
    endtask

    // One image: clear, ink scattered in a rectangle inside the filled corner, then
    // reads aimed mostly at the centred box, sometimes grown further and read again.
    task automatic run_frame();
        int unsigned sel;
        int unsigned lim_h;
        int unsigned lim_w;
        int unsigned box_h;
        int unsigned box_w;
        int unsigned r0;
        int unsigned c0;
        int unsigned half_h;
        int unsigned half_w;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            lim_h = FILL_R;
            lim_w = ARM;
            box_h = $urandom_range(60, FILL_R);
            box_w = $urandom_range(1, ARM);
        end else if (sel == 1) begin
            lim_h = ARM;
            lim_w = FILL_C;
            box_h = $urandom_range(1, ARM);
            box_w = $urandom_range(40, FILL_C);
        end else begin
            lim_h = SQ;
            lim_w = SQ;
            box_h = $urandom_range(1, SQ);
            box_w = $urandom_range(1, SQ);
        end
        r0 = $urandom_range(0, lim_h - box_h);
        c0 = $urandom_range(0, lim_w - box_w);
        half_h = (box_h / 2 + 2 > 35) ? 35 : box_h / 2 + 2;
        half_w = (box_w / 2 + 2 > 25) ? 25 : box_w / 2 + 2;
        send_item(FUNC_CLEAR, COORD_W'($urandom_range(0, 127)),
                  COORD_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        if (sel < 2) begin
            send_item(FUNC_WRITE, COORD_W'(r0), COORD_W'(c0), 1'b1);
            send_item(FUNC_WRITE, COORD_W'(r0 + box_h - 1), COORD_W'(c0 + box_w - 1), 1'b1);
        end
        repeat ($urandom_range(1, 2)) begin
            repeat ($urandom_range(4, 16)) begin
                if ($urandom_range(0, 14) == 0) send_noise();
                send_item(FUNC_WRITE, COORD_W'(r0 + $urandom_range(0, box_h - 1)),
                          COORD_W'(c0 + $urandom_range(0, box_w - 1)),
                          $urandom_range(0, 2) != 0);
            end
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 14) == 0) send_noise();
                if ($urandom_range(0, 4) == 0)
                    send_item(FUNC_READ, COORD_W'($urandom_range(0, 127)),
                              COORD_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                else
                    send_item(FUNC_READ, COORD_W'($urandom_range(35 - half_h, 34 + half_h)),
                              COORD_W'($urandom_range(25 - half_w, 24 + half_w)),
                              1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned c;
        int unsigned phase;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IMAGE_ROWS;
        cfg_wdata = '0;
        img_rows  = CFG_W'(MAX_ROWS);
        img_cols  = CFG_W'(MAX_COLS);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Only the corner in which every box is built is written up front, so no
        // read ever meets an entry that was never written; the random content
        // leaves stale ink for later boxes.
        for (r = 0; r < SQ; r++)
            for (c = 0; c < SQ; c++)
                send_item(FUNC_WRITE, COORD_W'(r), COORD_W'(c), 1'($urandom_range(0, 1)));
        for (r = SQ; r < FILL_R; r++)
            for (c = 0; c < ARM; c++)
                send_item(FUNC_WRITE, COORD_W'(r), COORD_W'(c), 1'($urandom_range(0, 1)));
        for (r = 0; r < ARM; r++)
            for (c = SQ; c < FILL_C; c++)
                send_item(FUNC_WRITE, COORD_W'(r), COORD_W'(c), 1'($urandom_range(0, 1)));
        wait_idle();
        set_image(8'd128, 8'd128);

        send_item(FUNC_CLEAR, 7'd0, 7'd0, 1'b0);
        send_item(FUNC_READ, 7'd0, 7'd0, 1'b0);
        send_item(FUNC_NONE, 7'd127, 7'd127, 1'b1);
        send_item(FUNC_WRITE, 7'd5, 7'd7, 1'b1);
        send_item(FUNC_READ, 7'd34, 7'd24, 1'b0);
        send_item(FUNC_READ, 7'd33, 7'd24, 1'b0);
        send_item(FUNC_CLEAR, 7'd3, 7'd9, 1'b1);
        send_item(FUNC_WRITE, 7'd0, 7'd0, 1'b1);
        send_item(FUNC_WRITE, 7'd71, 7'd1, 1'b1);
        send_item(FUNC_READ, 7'd0, 7'd0, 1'b1);
        send_item(FUNC_READ, 7'd69, 7'd25, 1'b0);
        send_item(FUNC_READ, 7'd70, 7'd24, 1'b0);
        send_item(FUNC_READ, 7'd0, 7'd50, 1'b0);
        send_item(FUNC_READ, 7'd127, 7'd127, 1'b1);
        send_item(FUNC_WRITE, 7'd0, 7'd0, 1'b0);
        send_item(FUNC_READ, 7'd0, 7'd24, 1'b0);
        send_item(FUNC_CLEAR, 7'd127, 7'd127, 1'b1);
        send_item(FUNC_WRITE, 7'd0, 7'd0, 1'b1);
        send_item(FUNC_WRITE, 7'd1, 7'd51, 1'b1);
        send_item(FUNC_READ, 7'd34, 7'd0, 1'b0);
        send_item(FUNC_READ, 7'd35, 7'd49, 1'b0);
        send_item(FUNC_CLEAR, 7'd127, 7'd127, 1'b1);
        send_item(FUNC_WRITE, 7'd5, 7'd5, 1'b1);
        send_item(FUNC_WRITE, 7'd6, 7'd6, 1'b1);
        send_item(FUNC_READ, 7'd33, 7'd23, 1'b0);
        send_item(FUNC_READ, 7'd34, 7'd24, 1'b0);
        send_item(FUNC_WRITE, 7'd1, 7'd0, 1'b1);
        send_item(FUNC_READ, 7'd35, 7'd25, 1'b0);
        wait_idle();
        set_image(8'd1, 8'd1);
        send_item(FUNC_CLEAR, 7'd0, 7'd0, 1'b0);
        send_item(FUNC_WRITE, 7'd1, 7'd0, 1'b1);
        send_item(FUNC_WRITE, 7'd0, 7'd0, 1'b1);
        send_item(FUNC_READ, 7'd34, 7'd24, 1'b0);

        counting = 1'b1;
        phase = 0;
        while (random_items < 250) begin
            wait_idle();
            case (phase % 8)
                0: set_image(8'd128, 8'd128);
                1: set_image(8'd1, 8'd1);
                2: set_image(8'd255, 8'd255);
                3: set_image(8'd0, CFG_W'($urandom_range(1, 128)));
                4: set_image(CFG_W'($urandom_range(1, 128)), CFG_W'($urandom_range(1, 128)));
                5: set_image(8'd128, CFG_W'($urandom_range(1, 60)));
                6: set_image(CFG_W'($urandom_range(1, 80)), 8'd0);
                default: set_image(CFG_W'($urandom_range(100, 255)),
                                   CFG_W'($urandom_range(100, 255)));
            endcase
            run_frame();
            phase++;
        end
        counting = 1'b0;

        wait_idle();
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
